// File: rtl/core/kerb_pkg.sv
// Shared types, codes and the consumer usage map for the key event report builder.
// Has no dependencies; the report builder core imports it.
`default_nettype none

package kerb_pkg;

    localparam logic MODE_PRESS   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    localparam logic [1:0] CLASS_NONE     = 2'd0;
    localparam logic [1:0] CLASS_BASIC    = 2'd1;
    localparam logic [1:0] CLASS_MOD      = 2'd2;
    localparam logic [1:0] CLASS_CONSUMER = 2'd3;

    typedef struct packed {
        logic [2:0]  row;
        logic [3:0]  col;
        logic [15:0] code;
        logic [1:0]  cls;
    } held_key_t;

    localparam logic [15:0] USAGE_MAP [0:6] = '{
        16'h00E2, 16'h00E9, 16'h00EA, 16'h00B5, 16'h00B6, 16'h00CD, 16'h00B7
    };

    function automatic logic [15:0] usage_of(input logic [7:0] low);
        logic [15:0] usage;
        usage = 16'h0000;
        if (low >= 8'd1 && low <= 8'd7)
        begin
            usage = USAGE_MAP[3'(low - 8'd1)];
        end
        return usage;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/key_event_report_builder_unit.sv
// Key event report builder: HID keyboard report with six key slots and a consumer usage.
// Depends on kerb_pkg for the entry type, class codes and the consumer usage map.
//
// Usage: one press or release event enters on the s_axis channel; exactly one
// result, holding the current report and two staging flags, leaves on the
// m_axis channel. The block works on one event at a time and drops s_axis_tready
// from the transfer until its result has been taken.
// A press of a basic key also searches the report slots for a free one. A release
// walks the pressed-key table through one memory read port and one shared
// comparator, one entry a cycle. The same comparator searches the report slots,
// one slot a cycle.
// When the receiver stalls, the result is held on m_axis until it is taken.
// Reset clears the report, the modifier byte, the consumer usage and the
// table count; table entries are not cleared and need no clearing pass.
`default_nettype none

module key_event_report_builder_unit
    import kerb_pkg::*;
#(
    parameter int ROWS         = 8,
    parameter int COLS         = 16,
    parameter int TABLE_DEPTH  = 128,
    parameter int REPORT_SLOTS = 6
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // key_row[2:0], key_col[6:3], key_code[22:7], zero[23]
    input  wire logic [23:0] s_axis_tdata,
    // mode[0], key_class[2:1]
    input  wire logic [2:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // modifier_bits[7:0], slot_zero..slot_five[55:8], consumer_usage[71:56]
    output logic [71:0]      m_axis_tdata,
    // keyboard_staged[0], consumer_staged[1]
    output logic [1:0]       m_axis_tuser
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = (REPORT_SLOTS > 1) ? $clog2(REPORT_SLOTS) : 1;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_EXEC    = 3'd1;
    localparam logic [2:0] S_SCAN    = 3'd2;
    localparam logic [2:0] S_MOVE_RD = 3'd3;
    localparam logic [2:0] S_MOVE_WR = 3'd4;
    localparam logic [2:0] S_SLOT    = 3'd5;
    localparam logic [2:0] S_OUT     = 3'd6;

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] scan_idx_reg;
    logic          pend_reg;
    logic [AW-1:0] hit_idx_reg;
    logic [SW-1:0] slot_idx_reg;
    logic          slot_rm_reg;
    logic [7:0]    tgt_reg;
    logic [7:0]    modifier_reg;
    logic [15:0]   consumer_reg;
    logic [7:0]    slots_reg [REPORT_SLOTS];
    logic          kstaged_reg;
    logic          cstaged_reg;

    logic          mode_reg;
    logic [2:0]    row_reg;
    logic [3:0]    col_reg;
    logic [15:0]   code_reg;
    logic [1:0]    cls_reg;

    held_key_t     tbl_mem [TABLE_DEPTH];
    held_key_t     rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    held_key_t     mem_wdata;

    logic [7:0]    cmp_a;
    logic [7:0]    cmp_b;
    logic          cmp_eq;
    logic          in_range;
    logic          found;
    logic [CW-1:0] hit_idx_c;
    logic          slot_last;
    logic [7:0]    out_slots [6];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);

    assign in_range  = (32'(row_reg) < ROWS) && (32'(col_reg) < COLS);
    assign hit_idx_c = scan_idx_reg - CW'(1);
    assign slot_last = (slot_idx_reg == SW'(REPORT_SLOTS - 1));

    // Shared equality unit: table position match or report slot search.
    always_comb
    begin
        if (state_reg == S_SLOT)
        begin
            cmp_a = slots_reg[slot_idx_reg];
            cmp_b = slot_rm_reg ? tgt_reg : 8'h00;
        end
        else
        begin
            cmp_a = {1'b0, rd_data_reg.row, rd_data_reg.col};
            cmp_b = {1'b0, row_reg, col_reg};
        end
    end

    assign cmp_eq = (cmp_a == cmp_b);
    assign found  = pend_reg && cmp_eq;

    always_comb
    begin
        if (state_reg == S_SCAN)
        begin
            rd_addr = scan_idx_reg[AW-1:0];
        end
        else
        begin
            rd_addr = count_reg[AW-1:0];
        end
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = count_reg[AW-1:0];
        mem_wdata = '{row: row_reg, col: col_reg, code: code_reg, cls: cls_reg};
        if (state_reg == S_EXEC && in_range && mode_reg == MODE_PRESS
            && cls_reg != CLASS_NONE && code_reg != 16'h0000
            && 32'(count_reg) < TABLE_DEPTH)
        begin
            mem_we = 1'b1;
        end
        else if (state_reg == S_MOVE_WR)
        begin
            mem_we    = 1'b1;
            mem_waddr = hit_idx_reg;
            mem_wdata = rd_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tbl_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= tbl_mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!in_range)
                begin
                    state_next = S_OUT;
                end
                else if (mode_reg == MODE_RELEASE)
                begin
                    state_next = S_SCAN;
                end
                else if (cls_reg == CLASS_BASIC && code_reg != 16'h0000)
                begin
                    state_next = S_SLOT;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_SCAN:
            begin
                if (found)
                begin
                    state_next = S_MOVE_RD;
                end
                else if (scan_idx_reg >= count_reg)
                begin
                    state_next = S_OUT;
                end
            end
            S_MOVE_RD:
            begin
                state_next = S_MOVE_WR;
            end
            S_MOVE_WR:
            begin
                state_next = (cls_reg == CLASS_BASIC) ? S_SLOT : S_OUT;
            end
            S_SLOT:
            begin
                if (cmp_eq || slot_last)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (m_axis_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            scan_idx_reg <= '0;
            pend_reg     <= 1'b0;
            slot_idx_reg <= '0;
            slot_rm_reg  <= 1'b0;
            modifier_reg <= 8'h00;
            consumer_reg <= 16'h0000;
            kstaged_reg  <= 1'b0;
            cstaged_reg  <= 1'b0;
            for (int i = 0; i < REPORT_SLOTS; i++)
            begin
                slots_reg[i] <= 8'h00;
            end
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    kstaged_reg  <= 1'b0;
                    cstaged_reg  <= 1'b0;
                    scan_idx_reg <= '0;
                    pend_reg     <= 1'b0;
                    slot_idx_reg <= '0;
                    slot_rm_reg  <= 1'b0;
                end
                S_EXEC:
                begin
                    if (in_range && mode_reg == MODE_PRESS
                        && cls_reg != CLASS_NONE && code_reg != 16'h0000)
                    begin
                        if (cls_reg == CLASS_CONSUMER)
                        begin
                            consumer_reg <= usage_of(code_reg[7:0]);
                            cstaged_reg  <= 1'b1;
                        end
                        else
                        begin
                            if (cls_reg == CLASS_MOD)
                            begin
                                modifier_reg <= modifier_reg | (8'd1 << code_reg[2:0]);
                            end
                            kstaged_reg <= 1'b1;
                        end
                        if (32'(count_reg) < TABLE_DEPTH)
                        begin
                            count_reg <= count_reg + CW'(1);
                        end
                    end
                end
                S_SCAN:
                begin
                    if (found)
                    begin
                        count_reg <= count_reg - CW'(1);
                    end
                    else if (scan_idx_reg < count_reg)
                    begin
                        scan_idx_reg <= scan_idx_reg + CW'(1);
                        pend_reg     <= 1'b1;
                    end
                end
                S_MOVE_RD:
                begin
                end
                S_MOVE_WR:
                begin
                    case (cls_reg)
                        CLASS_CONSUMER:
                        begin
                            consumer_reg <= 16'h0000;
                            cstaged_reg  <= 1'b1;
                        end
                        CLASS_MOD:
                        begin
                            modifier_reg <= modifier_reg & ~(8'd1 << code_reg[2:0]);
                            kstaged_reg  <= 1'b1;
                        end
                        CLASS_BASIC:
                        begin
                            slot_rm_reg <= 1'b1;
                            kstaged_reg <= 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_SLOT:
                begin
                    if (cmp_eq)
                    begin
                        slots_reg[slot_idx_reg] <= slot_rm_reg ? 8'h00 : tgt_reg;
                    end
                    else if (!slot_last)
                    begin
                        slot_idx_reg <= slot_idx_reg + SW'(1);
                    end
                end
                S_OUT:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // Event fields; on a table hit the key and class are replaced by the stored ones.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_axis_tvalid)
        begin
            mode_reg <= s_axis_tuser[0];
            cls_reg  <= s_axis_tuser[2:1];
            row_reg  <= s_axis_tdata[2:0];
            col_reg  <= s_axis_tdata[6:3];
            code_reg <= s_axis_tdata[22:7];
            tgt_reg  <= s_axis_tdata[14:7];
        end
        else if (state_reg == S_SCAN && found)
        begin
            cls_reg     <= rd_data_reg.cls;
            code_reg    <= rd_data_reg.code;
            tgt_reg     <= rd_data_reg.code[7:0];
            hit_idx_reg <= hit_idx_c[AW-1:0];
        end
    end

    for (genvar g = 0; g < 6; g++)
    begin : g_out_slot
        if (g < REPORT_SLOTS)
        begin : g_used
            assign out_slots[g] = slots_reg[g];
        end
        else
        begin : g_unused
            assign out_slots[g] = 8'h00;
        end
    end

    assign m_axis_tdata = {consumer_reg, out_slots[5], out_slots[4], out_slots[3],
                           out_slots[2], out_slots[1], out_slots[0], modifier_reg};
    assign m_axis_tuser = {cstaged_reg, kstaged_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= TABLE_DEPTH)
        else $error("pressed key count beyond table depth");

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while a result is pending");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
        (count_reg == $past(count_reg) + CW'(1) || count_reg == $past(count_reg) - CW'(1)))
        else $error("pressed key count moved by more than one");

    a_one_report: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(kstaged_reg && cstaged_reg))
        else $error("one event staged both reports");

    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == S_EXEC))
        else $error("accepted event not started");

endmodule

`default_nettype wire

// File: sim/key_event_report_builder_unit_tb.sv
// Self-checking testbench for key_event_report_builder_unit: a directed table, then random
// press and release traffic; results are checked against fixed reports or a behavioral predictor.
// Depends on kerb_pkg and the RTL of key_event_report_builder_unit only.

module key_event_report_builder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import kerb_pkg::*;

    localparam int TABLE_DEPTH  = 128;
    localparam int SLOT_COUNT   = 6;
    localparam int QUIET_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic        mode;
        logic [2:0]  row;
        logic [3:0]  col;
        logic [15:0] code;
        logic [1:0]  cls;
    } key_event_t;

    // Same bit order as {m_axis_tuser, m_axis_tdata}.
    typedef struct packed {
        logic            cst;
        logic            kst;
        logic [15:0]     usage;
        logic [5:0][7:0] slots;
        logic [7:0]      mods;
    } report_t;

    typedef struct packed {
        logic [2:0]  row;
        logic [3:0]  col;
        logic [15:0] code;
        logic [1:0]  cls;
    } tracked_key_t;

    typedef struct {
        key_event_t ev;
        bit         fixed;
        report_t    want;
    } directed_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    tracked_key_t    held_keys [TABLE_DEPTH];
    int              held_count;
    logic [7:0]      mod_byte;
    logic [5:0][7:0] key_slots;
    logic [15:0]     usage_now;

    report_t       pending_reports [$];
    directed_row_t directed_rows [$];
    int            errors;
    int            press_count;
    int            release_count;
    int            checked_count;
    int            table_full_presses;
    int            slots_full_presses;
    int            src_idle;
    int            sink_idle;
    int            quiet_cycles;

    key_event_report_builder_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [15:0] usage_for(logic [7:0] low);
        case (low)
            8'd1:    return 16'h00E2;
            8'd2:    return 16'h00E9;
            8'd3:    return 16'h00EA;
            8'd4:    return 16'h00B5;
            8'd5:    return 16'h00B6;
            8'd6:    return 16'h00CD;
            8'd7:    return 16'h00B7;
            default: return 16'h0000;
        endcase
    endfunction

    function automatic report_t build_report(key_event_t ev);
        report_t      r;
        tracked_key_t k;
        int           hit;
        bit           done;
        r = '0;
        hit = -1;
        done = 1'b0;
        if (ev.mode == MODE_PRESS)
        begin
            if (ev.cls != CLASS_NONE && ev.code != 16'h0000)
            begin
                if (ev.cls == CLASS_CONSUMER)
                begin
                    usage_now = usage_for(ev.code[7:0]);
                    r.cst = 1'b1;
                end
                else
                begin
                    if (ev.cls == CLASS_MOD)
                    begin
                        mod_byte[ev.code[2:0]] = 1'b1;
                    end
                    else
                    begin
                        for (int i = 0; i < SLOT_COUNT; i++)
                        begin
                            if (!done && key_slots[i] == 8'h00)
                            begin
                                key_slots[i] = ev.code[7:0];
                                done = 1'b1;
                            end
                        end
                        if (!done)
                        begin
                            slots_full_presses++;
                        end
                    end
                    r.kst = 1'b1;
                end
                if (held_count < TABLE_DEPTH)
                begin
                    held_keys[held_count] = '{ev.row, ev.col, ev.code, ev.cls};
                    held_count++;
                end
                else
                begin
                    table_full_presses++;
                end
            end
        end
        else
        begin
            for (int i = 0; i < held_count; i++)
            begin
                if (hit < 0 && held_keys[i].row == ev.row && held_keys[i].col == ev.col)
                begin
                    hit = i;
                end
            end
            if (hit >= 0)
            begin
                k = held_keys[hit];
                held_count--;
                held_keys[hit] = held_keys[held_count];
                if (k.cls == CLASS_CONSUMER)
                begin
                    usage_now = 16'h0000;
                    r.cst = 1'b1;
                end
                else if (k.cls == CLASS_MOD)
                begin
                    mod_byte[k.code[2:0]] = 1'b0;
                    r.kst = 1'b1;
                end
                else if (k.cls == CLASS_BASIC)
                begin
                    for (int i = 0; i < SLOT_COUNT; i++)
                    begin
                        if (!done && key_slots[i] == k.code[7:0])
                        begin
                            key_slots[i] = 8'h00;
                            done = 1'b1;
                        end
                    end
                    r.kst = 1'b1;
                end
            end
        end
        r.mods = mod_byte;
        r.slots = key_slots;
        r.usage = usage_now;
        return r;
    endfunction

    function automatic report_t rep(logic [7:0] mods, logic [47:0] slots, logic [15:0] usage,
                                    logic kst, logic cst);
        report_t r;
        r = '{cst, kst, usage, slots, mods};
        return r;
    endfunction

    function automatic void add_row(logic mode, int row, int col, logic [15:0] code,
                                    logic [1:0] cls, bit fixed, report_t want);
        directed_row_t d;
        d.ev = '{mode, 3'(row), 4'(col), code, cls};
        d.fixed = fixed;
        d.want = want;
        directed_rows.push_back(d);
    endfunction

    function automatic key_event_t random_press(bit live);
        key_event_t ev;
        logic [7:0] lo;
        logic [7:0] hi;
        ev.mode = MODE_PRESS;
        ev.row = 3'($urandom_range(0, 7));
        ev.col = 4'($urandom_range(0, 15));
        lo = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 12));
        hi = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'h00;
        ev.code = {hi, lo};
        if ($urandom_range(0, 15) == 0)
        begin
            ev.code = 16'($urandom);
        end
        ev.cls = 2'($urandom_range(1, 3));
        if (live)
        begin
            if (ev.code == 16'h0000)
            begin
                ev.code = 16'($urandom_range(1, 65535));
            end
        end
        else
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                ev.cls = CLASS_NONE;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                ev.code = 16'h0000;
            end
        end
        return ev;
    endfunction

    function automatic key_event_t random_release(bit held);
        key_event_t   ev;
        tracked_key_t k;
        ev.mode = MODE_RELEASE;
        ev.row = 3'($urandom_range(0, 7));
        ev.col = 4'($urandom_range(0, 15));
        ev.code = 16'($urandom);
        ev.cls = 2'($urandom_range(0, 3));
        if (held && held_count > 0)
        begin
            k = held_keys[$urandom_range(0, held_count - 1)];
            ev.row = k.row;
            ev.col = k.col;
        end
        return ev;
    endfunction

    task automatic send_event(key_event_t ev, bit fixed, report_t want);
        report_t predicted;
        while ($urandom_range(0, 99) < src_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, ev.code, ev.col, ev.row};
        s_axis_tuser <= {ev.cls, ev.mode};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        predicted = build_report(ev);
        pending_reports.push_back(fixed ? want : predicted);
        if (ev.mode == MODE_PRESS)
        begin
            press_count++;
        end
        else
        begin
            release_count++;
        end
    endtask

    task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
        if (errors < 40)
        begin
            $display("MISMATCH %s: got 0x%0h, want 0x%0h (result %0d)",
                     what, got, want, checked_count);
        end
        errors++;
    endtask

    task automatic check_report(report_t got);
        report_t want;
        if (pending_reports.size() == 0)
        begin
            flag_mismatch("result with no event pending, modifier byte", got.mods, 0);
        end
        else
        begin
            want = pending_reports.pop_front();
            checked_count++;
            if (got.mods !== want.mods)
            begin
                flag_mismatch("modifier byte", got.mods, want.mods);
            end
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                if (got.slots[i] !== want.slots[i])
                begin
                    flag_mismatch($sformatf("key slot %0d", i), got.slots[i], want.slots[i]);
                end
            end
            if (got.usage !== want.usage)
            begin
                flag_mismatch("consumer usage", got.usage, want.usage);
            end
            if (got.kst !== want.kst)
            begin
                flag_mismatch("keyboard staged", got.kst, want.kst);
            end
            if (got.cst !== want.cst)
            begin
                flag_mismatch("consumer staged", got.cst, want.cst);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            check_report(report_t'({m_axis_tuser, m_axis_tdata}));
        end
        m_axis_tready <= rst_n && ($urandom_range(0, 99) >= sink_idle);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("Verification failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int drained;
        errors = 0;
        press_count = 0;
        release_count = 0;
        checked_count = 0;
        table_full_presses = 0;
        slots_full_presses = 0;
        quiet_cycles = 0;
        held_count = 0;
        mod_byte = '0;
        key_slots = '0;
        usage_now = '0;
        src_idle = 35;
        sink_idle = 63;

        add_row(MODE_RELEASE, 0, 0, 16'h0000, CLASS_NONE, 1, rep(8'h00, 48'h0, 16'h0, 0, 0));
        add_row(MODE_PRESS, 1, 1, 16'h1234, CLASS_NONE, 1, rep(8'h00, 48'h0, 16'h0, 0, 0));
        add_row(MODE_PRESS, 1, 2, 16'h0000, CLASS_BASIC, 1, rep(8'h00, 48'h0, 16'h0, 0, 0));
        add_row(MODE_PRESS, 0, 0, 16'hFF04, CLASS_BASIC, 1, rep(8'h00, 48'h04, 16'h0, 1, 0));
        add_row(MODE_PRESS, 7, 15, 16'hFFFF, CLASS_MOD, 1, rep(8'h80, 48'h04, 16'h0, 1, 0));
        add_row(MODE_PRESS, 7, 14, 16'h0008, CLASS_MOD, 1, rep(8'h81, 48'h04, 16'h0, 1, 0));
        add_row(MODE_PRESS, 3, 3, 16'h0001, CLASS_CONSUMER, 1,
                rep(8'h81, 48'h04, 16'h00E2, 0, 1));
        add_row(MODE_PRESS, 3, 4, 16'hAB07, CLASS_CONSUMER, 0, '0);
        add_row(MODE_PRESS, 3, 5, 16'h0008, CLASS_CONSUMER, 0, '0);
        add_row(MODE_PRESS, 2, 2, 16'h0100, CLASS_BASIC, 0, '0);
        for (int i = 0; i < 5; i++)
        begin
            add_row(MODE_PRESS, 4, i, 16'(5 + i), CLASS_BASIC, 0, '0);
        end
        add_row(MODE_PRESS, 4, 5, 16'h000A, CLASS_BASIC, 0, '0);
        add_row(MODE_RELEASE, 0, 0, 16'h0000, CLASS_NONE, 0, '0);
        add_row(MODE_PRESS, 4, 6, 16'h000A, CLASS_BASIC, 0, '0);
        add_row(MODE_RELEASE, 2, 2, 16'h0000, CLASS_NONE, 0, '0);
        add_row(MODE_RELEASE, 3, 3, 16'h0000, CLASS_NONE, 0, '0);
        add_row(MODE_RELEASE, 4, 5, 16'h0000, CLASS_NONE, 0, '0);
        add_row(MODE_RELEASE, 7, 15, 16'h0000, CLASS_NONE, 0, '0);
        add_row(MODE_RELEASE, 7, 14, 16'hFFFF, CLASS_CONSUMER, 0, '0);
        add_row(MODE_PRESS, 5, 5, 16'h0033, CLASS_BASIC, 0, '0);
        add_row(MODE_PRESS, 5, 5, 16'h0002, CLASS_MOD, 0, '0);
        add_row(MODE_RELEASE, 5, 5, 16'h0000, CLASS_NONE, 0, '0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:       begin src_idle = 35; sink_idle = 63; end
                1:       begin src_idle = 63; sink_idle = 35; end
                default: begin src_idle = 0;  sink_idle = 0;  end
            endcase
            if (phase == 0)
            begin
                foreach (directed_rows[i])
                begin
                    send_event(directed_rows[i].ev, directed_rows[i].fixed,
                               directed_rows[i].want);
                end
            end
            // Overfill the key table, then empty it again through held positions.
            repeat (140) send_event(random_press(1), 0, '0);
            drained = 0;
            while (held_count > 0 && drained < 160)
            begin
                send_event(random_release(1), 0, '0);
                drained++;
            end
            repeat (150)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: send_event(random_press(0), 0, '0);
                    5, 6, 7, 8:    send_event(random_release(1), 0, '0);
                    default:       send_event(random_release(0), 0, '0);
                endcase
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d presses and %0d releases; %0d results compared field by field.",
                 press_count, release_count, checked_count);
        $display("Presses on a full key table: %0d; basic presses with every slot taken: %0d.",
                 table_full_presses, slots_full_presses);
        if (errors == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("%0d mismatches found", errors);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
